// File: design/gtp_pkg.sv
// ----------------------------------------------------------------------------
// gtp_pkg
// Shared types and fixed constants of the Goertzel tone power unit.
// ----------------------------------------------------------------------------
package gtp_pkg;

   // Fixed field widths
   localparam int COEF_BITS  = 16;
   localparam int SHIFT_BITS = 6;
   localparam int POWER_BITS = 48;

   // Multiplier digit: the wide operand is multiplied by one digit per cycle
   localparam int DIGIT_BITS = 16;

   // Register indexes on the csr port
   localparam logic REG_COEF  = 1'b0;
   localparam logic REG_SHIFT = 1'b1;

   // Multiplicand select
   typedef enum logic [1:0] {
      ASEL_COEF,   // coefficient register
      ASEL_U,      // q1*2^F - c*q2, held from the first power pass
      ASEL_Q2F     // q2*2^F
   } asel_type;

   // Multiplier (digit source) select
   typedef enum logic {
      BSEL_Q1,
      BSEL_Q2
   } bsel_type;

   // Accumulator start value on the first digit
   typedef enum logic [1:0] {
      INIT_KEEP,   // keep running sum
      INIT_ZERO,
      INIT_ROUND,  // 2^(F-1), round half up
      INIT_Q1F     // q1*2^F
   } init_type;

   // Controller to datapath
   typedef struct packed {
      logic     capture;   // latch input beat
      logic     mac;       // one digit multiply-accumulate step
      asel_type a_sel;
      bsel_type b_sel;
      init_type init_sel;
      logic     sub;       // subtract partial product
      logic     rec_fin;   // finish recurrence, update delay line
      logic     load_u;    // hold accumulator as multiplicand
      logic     shift;     // scale block power
      logic     out_load;  // clamp power into output register, clear state
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic mac_last;   // current digit is the top one
      logic block_end;  // captured beat closes a block
      logic out_free;   // output register can take a result
   } status_type;

endpackage

// File: design/gtp_dp.sv
// ----------------------------------------------------------------------------
// gtp_dp
// Datapath: delay line, digit-serial multiply-accumulate, power scaling,
// configuration registers and the output register.
// ----------------------------------------------------------------------------
module gtp_dp #(
   parameter int SAMPLE_BITS    = 16,
   parameter int COEF_FRAC_BITS = 14,
   parameter int STATE_BITS     = 40
) (
   input  logic                              clock,
   input  logic                              reset,
   input  gtp_pkg::cmd_type                  cmd,
   output gtp_pkg::status_type               status,
   input  logic [SAMPLE_BITS-1:0]            sample,
   input  logic                              block_end,
   input  logic                              csr_we,
   input  logic                              csr_addr,
   input  logic [gtp_pkg::COEF_BITS-1:0]     csr_wdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [gtp_pkg::POWER_BITS-1:0]    power,
   output logic                              saturated
);
   import gtp_pkg::*;

   localparam int FW    = COEF_FRAC_BITS;
   localparam int MX    = (FW > COEF_BITS) ? FW : COEF_BITS;
   localparam int AW    = STATE_BITS + MX + 1;        // multiplicand width
   localparam int TW    = 2 * STATE_BITS + MX + 2;    // accumulator width
   localparam int ND    = (STATE_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
   localparam int CNT_W = (ND > 1) ? $clog2(ND) : 1;
   localparam int BW    = ND * DIGIT_BITS;
   localparam int PW    = AW + DIGIT_BITS + 1;
   localparam int SH_W  = $clog2(FW + 64);

   localparam logic signed [TW-1:0] SMAX =
      {{(TW - STATE_BITS + 1){1'b0}}, {(STATE_BITS - 1){1'b1}}};
   localparam logic signed [TW-1:0] SMIN = ~SMAX;
   localparam logic signed [TW-1:0] PMAX =
      {{(TW - POWER_BITS){1'b0}}, {POWER_BITS{1'b1}}};
   localparam logic signed [TW-1:0] ROUND_C = TW'(1) << (FW - 1);

   logic signed [STATE_BITS-1:0]  q1_ff, q1_in, q2_ff, q2_in;
   logic                          ovf_ff, ovf_in;
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic                          end_ff;
   logic signed [COEF_BITS-1:0]   coef_ff;
   logic [SHIFT_BITS-1:0]         pshift_ff;
   logic signed [AW-1:0]          u_ff;
   logic signed [TW-1:0]          acc_ff, acc_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [POWER_BITS-1:0]         power_ff, power_in;
   logic                          sat_ff, sat_in;
   logic                          out_valid_ff, out_valid_in;

   logic signed [AW-1:0]          opa;
   logic signed [STATE_BITS-1:0]  opb;
   logic signed [BW-1:0]          b_ext;
   logic [DIGIT_BITS-1:0]         slice;
   logic                          top;
   logic signed [DIGIT_BITS:0]    digit;
   logic signed [PW-1:0]          prod;
   logic signed [TW-1:0]          pp, init_val, base, mac_val;
   logic signed [TW-1:0]          rsum;
   logic signed [STATE_BITS-1:0]  q0;
   logic                          rec_hit;
   logic [SH_W-1:0]               sh;

   // digit-serial multiplier
   always_comb begin
      unique case (cmd.a_sel)
         ASEL_COEF: opa = AW'(coef_ff);
         ASEL_U:    opa = u_ff;
         ASEL_Q2F:  opa = AW'(q2_ff) <<< FW;
         default:   opa = '0;
      endcase
      opb   = (cmd.b_sel == BSEL_Q1) ? q1_ff : q2_ff;
      b_ext = BW'(opb);
      slice = b_ext[cnt_ff * DIGIT_BITS +: DIGIT_BITS];
      top   = (cnt_ff == CNT_W'(ND - 1));
      // lower digits unsigned, top digit carries the sign
      digit = signed'({top & slice[DIGIT_BITS-1], slice});
      prod  = opa * digit;
      pp    = TW'(prod) <<< (cnt_ff * DIGIT_BITS);
      unique case (cmd.init_sel)
         INIT_KEEP:  init_val = acc_ff;
         INIT_ZERO:  init_val = '0;
         INIT_ROUND: init_val = ROUND_C;
         INIT_Q1F:   init_val = TW'(q1_ff) <<< FW;
         default:    init_val = '0;
      endcase
      base    = (cnt_ff == '0) ? init_val : acc_ff;
      mac_val = cmd.sub ? (base - pp) : (base + pp);
   end

   // recurrence finish: round, subtract q2, add sample, saturate
   always_comb begin
      rsum    = (acc_ff >>> FW) - TW'(q2_ff) + TW'(sample_ff);
      rec_hit = 1'b0;
      if (rsum > SMAX) begin
         q0      = SMAX[STATE_BITS-1:0];
         rec_hit = 1'b1;
      end else if (rsum < SMIN) begin
         q0      = SMIN[STATE_BITS-1:0];
         rec_hit = 1'b1;
      end else begin
         q0 = rsum[STATE_BITS-1:0];
      end
   end

   always_comb begin
      sh = SH_W'(FW) + SH_W'(pshift_ff);

      acc_in = acc_ff;
      if (cmd.mac) begin
         acc_in = mac_val;
      end else if (cmd.shift) begin
         acc_in = acc_ff >>> sh;
      end

      cnt_in = cnt_ff;
      if (cmd.mac) begin
         cnt_in = top ? '0 : cnt_ff + CNT_W'(1);
      end

      q1_in  = q1_ff;
      q2_in  = q2_ff;
      ovf_in = ovf_ff;
      if (cmd.rec_fin) begin
         q2_in  = q1_ff;
         q1_in  = q0;
         ovf_in = ovf_ff | rec_hit;
      end else if (cmd.out_load) begin
         q1_in  = '0;
         q2_in  = '0;
         ovf_in = 1'b0;
      end

      // negative power clamps to zero without flagging
      if (acc_ff[TW-1]) begin
         power_in = '0;
         sat_in   = ovf_ff;
      end else if (acc_ff > PMAX) begin
         power_in = '1;
         sat_in   = 1'b1;
      end else begin
         power_in = acc_ff[POWER_BITS-1:0];
         sat_in   = ovf_ff;
      end

      out_valid_in = out_valid_ff;
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q1_ff        <= '0;
         q2_ff        <= '0;
         ovf_ff       <= 1'b0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
         coef_ff      <= '0;
         pshift_ff    <= SHIFT_BITS'(16);
      end else begin
         q1_ff        <= q1_in;
         q2_ff        <= q2_in;
         ovf_ff       <= ovf_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
         if (csr_we) begin
            unique case (csr_addr)
               REG_COEF:  coef_ff   <= signed'(csr_wdata);
               REG_SHIFT: pshift_ff <= csr_wdata[SHIFT_BITS-1:0];
               default:   coef_ff   <= coef_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (cmd.capture) begin
         sample_ff <= signed'(sample);
         end_ff    <= block_end;
      end
      if (cmd.load_u) begin
         u_ff <= acc_ff[AW-1:0];
      end
      if (cmd.out_load) begin
         power_ff <= power_in;
         sat_ff   <= sat_in;
      end
   end

   assign status.mac_last  = top;
   assign status.block_end = end_ff;
   assign status.out_free  = ~out_valid_ff | rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign power      = power_ff;
   assign saturated  = sat_ff;

endmodule

// File: design/gtp_ctrl.sv
// ----------------------------------------------------------------------------
// gtp_ctrl
// Sequencer: steps the datapath through the recurrence and the block power.
// ----------------------------------------------------------------------------
module gtp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  gtp_pkg::status_type status,
   output gtp_pkg::cmd_type    cmd
);
   import gtp_pkg::*;

   typedef enum logic [3:0] {
      IDLE,
      REC_MAC,
      REC_FIN,
      U_MAC,
      U_LOAD,
      T1_MAC,
      T2_MAC,
      SHIFT,
      EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      req_tready = 1'b0;
      unique case (state_ff)
         IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) state_in = REC_MAC;
         end
         REC_MAC: begin
            cmd.mac      = 1'b1;
            cmd.a_sel    = ASEL_COEF;
            cmd.b_sel    = BSEL_Q1;
            cmd.init_sel = INIT_ROUND;
            if (status.mac_last) state_in = REC_FIN;
         end
         REC_FIN: begin
            // next beat overlaps the finish cycle inside a block
            cmd.rec_fin = 1'b1;
            req_tready  = ~status.block_end;
            priority if (status.block_end) begin
               state_in = U_MAC;
            end else if (req_tvalid) begin
               state_in = REC_MAC;
            end else begin
               state_in = IDLE;
            end
         end
         U_MAC: begin
            cmd.mac      = 1'b1;
            cmd.a_sel    = ASEL_COEF;
            cmd.b_sel    = BSEL_Q2;
            cmd.init_sel = INIT_Q1F;
            cmd.sub      = 1'b1;
            if (status.mac_last) state_in = U_LOAD;
         end
         U_LOAD: begin
            cmd.load_u = 1'b1;
            state_in   = T1_MAC;
         end
         T1_MAC: begin
            cmd.mac      = 1'b1;
            cmd.a_sel    = ASEL_U;
            cmd.b_sel    = BSEL_Q1;
            cmd.init_sel = INIT_ZERO;
            if (status.mac_last) state_in = T2_MAC;
         end
         T2_MAC: begin
            cmd.mac      = 1'b1;
            cmd.a_sel    = ASEL_Q2F;
            cmd.b_sel    = BSEL_Q2;
            cmd.init_sel = INIT_KEEP;
            if (status.mac_last) state_in = SHIFT;
         end
         SHIFT: begin
            cmd.shift = 1'b1;
            state_in  = EMIT;
         end
         EMIT: begin
            cmd.out_load = status.out_free;
            if (status.out_free) state_in = IDLE;
         end
         default: state_in = IDLE;
      endcase
      accept      = req_tvalid & req_tready;
      cmd.capture = accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: design/goertzel_tone_power_unit.sv
// ----------------------------------------------------------------------------
// goertzel_tone_power_unit
// Single-bin Goertzel detector: recurrence per sample, block power at the end.
// ----------------------------------------------------------------------------
// Each sample steps c*q1 through the one shared 16-bit-digit multiplier, one
//   digit at a time, ND = ceil(STATE_BITS/16) digits (3 at defaults); inside a
//   block the next sample is taken while the previous one finishes. After a
//   block-end beat, power is three digit-serial products on the same multiplier.
// A finished result waits in the output register while new samples are taken.
// Reset (synchronous): delay line, overflow flag and handshake cleared,
//   coefficient = 0, power_shift = 16.
// ----------------------------------------------------------------------------
module goertzel_tone_power_unit #(
   parameter int SAMPLE_BITS    = 16,
   parameter int COEF_FRAC_BITS = 14,
   parameter int STATE_BITS     = 40
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // input samples
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      req_tdata,   // [SAMPLE_BITS-1:0] sample
   input  logic                                  req_tlast,   // block_end
   // block power results
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [gtp_pkg::POWER_BITS-1:0]        rsp_tdata,   // [47:0] power
   output logic                                  rsp_tuser,   // [0] saturated
   // register writes: 0 = coefficient, 1 = power_shift
   input  logic                                  csr_we,
   input  logic                                  csr_addr,
   input  logic [gtp_pkg::COEF_BITS-1:0]         csr_wdata
);
   import gtp_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Controller: sequences the digit steps of each product
   gtp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Datapath: only the low SAMPLE_BITS of the beat carry the sample;
   // padding bits above are ignored.
   gtp_dp #(
      .SAMPLE_BITS    (SAMPLE_BITS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS),
      .STATE_BITS     (STATE_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .sample     (req_tdata[SAMPLE_BITS-1:0]),
      .block_end  (req_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .power      (rsp_tdata),
      .saturated  (rsp_tuser)
   );

endmodule

// File: bench/tb_goertzel_tone_power_unit.sv
// ----------------------------------------------------------------------------
// tb_goertzel_tone_power_unit
// Self-checking bench for the single-bin Goertzel tone power unit. A local
// bit-exact predictor runs the recurrence and block power on every accepted
// sample beat; each result beat is compared against the oldest predicted
// block power. Covers directed corners, power saturation, random blocks
// under several register settings, random idling and long back-pressure.
// ----------------------------------------------------------------------------
module tb_goertzel_tone_power_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import gtp_pkg::*;

   localparam int SAMPLE_BITS    = 16;
   localparam int COEF_FRAC_BITS = 14;
   localparam int STATE_BITS     = 40;
   localparam int DATA_BITS      = ((SAMPLE_BITS + 7) / 8) * 8;

   // margin for a block-end result plus one sample still in flight
   localparam int SETTLE_CYCLES  = 40;
   // long receiver hold-off, enough to fill the output register and stall input
   localparam int HOLD_CYCLES    = 400;
   // cycles with no beat on either side before the run is declared hung
   localparam int WATCHDOG_LIMIT = 5000;

   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 16'sh7FFF;
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = 16'sh8000;

   localparam logic signed [127:0] ROUND_HALF = 128'sd1 <<< (COEF_FRAC_BITS - 1);
   localparam logic signed [127:0] STATE_MAX  = (128'sd1 <<< (STATE_BITS - 1)) - 128'sd1;
   localparam logic signed [127:0] STATE_MIN  = -(128'sd1 <<< (STATE_BITS - 1));
   localparam logic signed [127:0] POWER_MAX  = (128'sd1 <<< POWER_BITS) - 128'sd1;

   typedef struct {
      logic [POWER_BITS-1:0] power;
      logic                  saturated;
   } tone_power_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [DATA_BITS-1:0]   req_tdata;   // [15:0] sample
   logic                   req_tlast;   // block_end
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [POWER_BITS-1:0]  rsp_tdata;   // [47:0] power
   logic                   rsp_tuser;   // [0] saturated
   logic                   csr_we;
   logic                   csr_addr;
   logic [COEF_BITS-1:0]   csr_wdata;

   // Predicted block powers, oldest first
   tone_power_type block_powers_due[$];

   // Predictor copy of registers and delay line
   logic signed [COEF_BITS-1:0]  coef_mirror;
   logic [SHIFT_BITS-1:0]        shift_mirror;
   logic signed [STATE_BITS-1:0] q1_mirror;
   logic signed [STATE_BITS-1:0] q2_mirror;
   logic                         overflow_mirror;

   // Idling controls shared by the sender, the receiver and the tests
   bit source_gaps_on;
   bit sink_gaps_on;
   bit hold_request;

   int mismatches;
   int idle_cycles;

   goertzel_tone_power_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Predictor: one recurrence step per accepted sample, block power on
   // block_end. All math is exact in 128 bits (products stay below 2^95).
   // ------------------------------------------------------------------------
   function automatic void advance_goertzel(input logic signed [SAMPLE_BITS-1:0] smp,
                                            input logic last);
      logic signed [127:0] c_w;
      logic signed [127:0] q1_w;
      logic signed [127:0] q2_w;
      logic signed [127:0] s_w;
      logic signed [127:0] acc;
      tone_power_type      res;
      c_w  = coef_mirror;
      q1_w = q1_mirror;
      q2_w = q2_mirror;
      s_w  = smp;
      // c*q1 rounded half up, then the exact feed-forward terms
      acc = (c_w * q1_w + ROUND_HALF) >>> COEF_FRAC_BITS;
      acc = acc - q2_w + s_w;
      if (acc > STATE_MAX) begin
         acc = STATE_MAX;
         overflow_mirror = 1'b1;
      end else if (acc < STATE_MIN) begin
         acc = STATE_MIN;
         overflow_mirror = 1'b1;
      end
      q2_mirror = q1_mirror;
      q1_mirror = acc[STATE_BITS-1:0];
      if (!last) return;

      q1_w = q1_mirror;
      q2_w = q2_mirror;
      acc = ((q1_w * q1_w + q2_w * q2_w) <<< COEF_FRAC_BITS) - c_w * q1_w * q2_w;
      acc = acc >>> (COEF_FRAC_BITS + shift_mirror);
      res.saturated = overflow_mirror;
      if (acc < 0) begin
         res.power = '0;            // negative power clamps silently
      end else if (acc > POWER_MAX) begin
         res.power     = '1;
         res.saturated = 1'b1;
      end else begin
         res.power = acc[POWER_BITS-1:0];
      end
      block_powers_due = {block_powers_due, res};
      q1_mirror       = '0;
      q2_mirror       = '0;
      overflow_mirror = 1'b0;
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0:       return SAMPLE_MAX;
         1:       return SAMPLE_MIN;
         2:       return SAMPLE_BITS'(int'($urandom_range(0, 64)) - 32);
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Shared driver tasks; all are entered in a rising-edge time step.
   // ------------------------------------------------------------------------
   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] smp, input logic last);
      int gap;
      gap = source_gaps_on ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= smp;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      advance_goertzel(smp, last);
   endtask

   task automatic send_block(input int len);
      for (int i = 0; i < len; i++) send_sample(pick_sample(), i == len - 1);
   endtask

   // Sender pauses until every predicted block power has come back
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (block_powers_due.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [COEF_BITS-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == REG_COEF) coef_mirror = value;
      else shift_mirror = value[SHIFT_BITS-1:0];
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   task automatic test_directed();
      // reset values: c = 0, shift 16; single-beat blocks at the sample extremes
      send_sample(SAMPLE_MAX, 1'b1);
      send_sample(SAMPLE_MIN, 1'b1);
      send_sample('0, 1'b1);
      // beats without block_end give no result
      send_sample(16'sh0001, 1'b0);
      send_sample(16'shFFFF, 1'b0);
      send_sample(SAMPLE_MAX, 1'b1);
      wait_idle();

      // c just below 2, no shift: fast growth of the delay line
      write_reg(REG_COEF, 16'h7FFF);
      write_reg(REG_SHIFT, 16'h0000);
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MAX, 1'b1);
      send_sample(SAMPLE_MIN, 1'b0);
      send_sample(SAMPLE_MIN, 1'b1);
      wait_idle();

      // c = -2, widest shift; unused upper write bits must be dropped
      write_reg(REG_COEF, 16'h8000);
      write_reg(REG_SHIFT, 16'hFFFF);
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MIN, 1'b0);
      send_sample(SAMPLE_MAX, 1'b1);
      wait_idle();

      // c = 1, rounding of c*q1 on odd values
      write_reg(REG_COEF, 16'h4000);
      write_reg(REG_SHIFT, 16'h0005);
      send_sample(16'sh5555, 1'b0);
      send_sample(16'shAAAA, 1'b0);
      send_sample('0, 1'b0);
      send_sample(16'sh1234, 1'b1);
      send_sample(SAMPLE_MIN, 1'b1);
      wait_idle();
   endtask

   // c = -2 with a Nyquist-rate input grows quadratically; stopped well before
   // the state clamps, so only the power saturates
   task automatic test_power_saturation();
      source_gaps_on = 1'b0;
      write_reg(REG_COEF, 16'h8000);
      write_reg(REG_SHIFT, 16'd0);
      for (int i = 0; i < 700; i++)
         send_sample((i % 2 == 0) ? SAMPLE_MAX : SAMPLE_MIN, i == 699);
      wait_idle();
   endtask

   task automatic test_random_blocks();
      logic [COEF_BITS-1:0] coef;
      logic [SHIFT_BITS-1:0] shamt;
      int sent;
      int len;
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0:       coef = 16'h7FFF;
            1:       coef = 16'h8000;
            2:       coef = 16'h0000;
            default: coef = COEF_BITS'($urandom);
         endcase
         case (phase)
            0:       shamt = 6'd0;
            1:       shamt = 6'd63;
            default: shamt = SHIFT_BITS'($urandom_range(8, 40));
         endcase
         write_reg(REG_COEF, coef);
         write_reg(REG_SHIFT, {10'($urandom), shamt});
         // one phase runs flat out on both sides
         source_gaps_on = (phase != 3);
         sink_gaps_on   = (phase != 3);
         sent = 0;
         while (sent < 30) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
            send_block(len);
            sent += len;
         end
         wait_idle();
      end
   endtask

   // receiver stalls long while short blocks keep coming: output fills, input stalls
   task automatic test_backpressure();
      source_gaps_on = 1'b0;
      sink_gaps_on   = 1'b1;
      write_reg(REG_COEF, 16'h2D41);
      write_reg(REG_SHIFT, 16'd12);
      hold_request = 1'b1;
      for (int i = 0; i < 20; i++) send_block($urandom_range(1, 2));
      wait_idle();
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tlast  <= 1'b0;
      csr_we     <= 1'b0;
      csr_addr   <= REG_COEF;
      csr_wdata  <= '0;
      coef_mirror     = '0;
      shift_mirror    = SHIFT_BITS'(16);
      q1_mirror       = '0;
      q2_mirror       = '0;
      overflow_mirror = 1'b0;
      source_gaps_on  = 1'b1;
      sink_gaps_on    = 1'b1;
      hold_request    = 1'b0;
      mismatches      = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_power_saturation();
      test_random_blocks();
      test_backpressure();

      wait_idle();
      if (mismatches == 0) $display("tb_goertzel_tone_power_unit: PASS");
      else $display("tb_goertzel_tone_power_unit: FAIL");
      $finish;
   end

   // Result sink: random stall before each beat, one long hold-off on request
   initial begin
      int stall;
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = sink_gaps_on ? $urandom_range(0, 10) : 0;
         if (hold_request) begin
            stall        = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Result checker: every result beat against the oldest prediction
   always @(posedge clock) begin
      tone_power_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (block_powers_due.size() == 0) begin
            $error("unexpected result beat: power %0d saturated %0b", rsp_tdata, rsp_tuser);
            mismatches++;
         end else begin
            want = block_powers_due.pop_front();
            if (rsp_tdata !== want.power) begin
               $error("power: expected %0d, got %0d", want.power, rsp_tdata);
               mismatches++;
            end
            if (rsp_tuser !== want.saturated) begin
               $error("saturated: expected %0b, got %0b", want.saturated, rsp_tuser);
               mismatches++;
            end
         end
      end
   end

   // Watchdog: no beat on either side for too long means the block hung
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_goertzel_tone_power_unit: FAIL");
            $finish;
         end
      end
   end

endmodule

// File: goertzel_tone_power_unit.f
design/gtp_pkg.sv
design/gtp_dp.sv
design/gtp_ctrl.sv
design/goertzel_tone_power_unit.sv
bench/tb_goertzel_tone_power_unit.sv
